@@ src/pva_pkg.sv @@
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared widths, arithmetic constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int VOICE_COUNT_DEF  = 8;
    localparam int BLOCK_FRAMES_DEF = 128;

    localparam int NOTE_W    = 7;
    localparam int TIME_W    = 64;
    localparam int AGE_W     = 64;
    localparam int IDX_OUT_W = 3;
    localparam int FRAME_W   = 7;
    localparam int ACT_OUT_W = 4;

    // Frame = floor(d * 441 / 10000000), clamped to the block.
    localparam int FRAME_CAP  = 127;
    localparam int RATE_NUM   = 441;
    localparam int RATE_DEN   = 10000000;
    localparam int DIFF_BOUND = 3000000;
    localparam int DIFF_W     = 22;

    // The frame is taken as (d * RECIP_MUL) >> RECIP_SHIFT, where RECIP_MUL is
    // 441 * 2^45 / 10000000 rounded up. The rounding error stays below one
    // count for every difference under DIFF_BOUND, so the result is exact.
    localparam int RECIP_MUL   = 1551630810;
    localparam int RECIP_SHIFT = 45;
    localparam int PROD_W      = 53;
    localparam int QUO_W       = 8;

    typedef struct packed {
        logic load;
        logic on_commit;
        logic off_emit;
    } t_cmd;

    typedef struct packed {
        logic on;
        logic frame_done;
        logic scan_done;
        logic pend_any;
        logic pend_last;
        logic out_free;
    } t_status;

endpackage

@@ src/pva_frame.sv @@
// ----------------------------------------------------------------------------
// Frame offset unit
// Converts an event time into a sample offset with one reciprocal multiply,
// registered in the cycle after the time difference is captured.
// ----------------------------------------------------------------------------
module pva_frame #(
    parameter int BLOCK_FRAMES = pva_pkg::BLOCK_FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pva_pkg::TIME_W-1:0]   i_event_time_ns,
    input  logic [pva_pkg::TIME_W-1:0]   i_block_start_ns,
    output logic                         o_done,
    output logic [pva_pkg::FRAME_W-1:0]  o_frame
);

    localparam int FRAME_MAX = ((BLOCK_FRAMES - 1) < pva_pkg::FRAME_CAP) ?
                               (BLOCK_FRAMES - 1) : pva_pkg::FRAME_CAP;

    logic                          r_calc;
    logic                          r_done;
    logic [pva_pkg::TIME_W-1:0]    r_diff;
    logic                          r_le;
    logic                          r_big;
    logic [pva_pkg::QUO_W-1:0]     r_quo;
    logic [pva_pkg::PROD_W-1:0]    w_prod;

    // Only differences below the bound reach the quotient, so 22 bits suffice.
    assign w_prod = pva_pkg::PROD_W'(r_diff[pva_pkg::DIFF_W-1:0]) *
                    pva_pkg::PROD_W'(pva_pkg::RECIP_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calc <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_calc <= 1'b1;
            r_done <= 1'b0;
        end else if (r_calc) begin
            r_calc <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_diff <= i_event_time_ns - i_block_start_ns;
            r_le   <= (i_event_time_ns <= i_block_start_ns);
        end else if (r_calc) begin
            r_big <= (r_diff >= pva_pkg::TIME_W'(pva_pkg::DIFF_BOUND));
            r_quo <= w_prod[pva_pkg::PROD_W-1:pva_pkg::RECIP_SHIFT];
        end
    end

    always_comb begin
        if (r_le) begin
            o_frame = '0;
        end else if (r_big || (r_quo > pva_pkg::QUO_W'(FRAME_MAX))) begin
            o_frame = pva_pkg::FRAME_W'(FRAME_MAX);
        end else begin
            o_frame = r_quo[pva_pkg::FRAME_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

@@ src/pva_dpath.sv @@
// ----------------------------------------------------------------------------
// Voice allocator datapath
// Voice table, age memory with oldest-voice scan, release queue and the
// registered result stage.
// ----------------------------------------------------------------------------
module pva_dpath #(
    parameter int VOICE_COUNT  = pva_pkg::VOICE_COUNT_DEF,
    parameter int BLOCK_FRAMES = pva_pkg::BLOCK_FRAMES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pva_pkg::t_cmd                  i_cmd,
    output pva_pkg::t_status               o_status,
    input  logic                           i_note_on,
    input  logic [pva_pkg::NOTE_W-1:0]     i_note_number,
    input  logic [pva_pkg::TIME_W-1:0]     i_event_time_ns,
    input  logic [pva_pkg::TIME_W-1:0]     i_block_start_ns,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [pva_pkg::IDX_OUT_W-1:0]  o_voice_index,
    output logic [pva_pkg::NOTE_W-1:0]     o_voice_note,
    output logic                           o_gate,
    output logic [pva_pkg::FRAME_W-1:0]    o_frame_offset,
    output logic [pva_pkg::ACT_OUT_W-1:0]  o_active_voices,
    output logic                           o_last_result
);

    localparam int IDX_W = $clog2(VOICE_COUNT);
    localparam int CNT_W = $clog2(VOICE_COUNT + 1);

    logic [pva_pkg::FRAME_W-1:0]   w_frame;
    logic                          w_frame_done;

    logic                          r_on;
    logic [pva_pkg::NOTE_W-1:0]    r_in_note;

    logic [VOICE_COUNT-1:0]        r_active;
    logic [pva_pkg::NOTE_W-1:0]    r_note [VOICE_COUNT];
    logic [pva_pkg::AGE_W-1:0]     r_age_mem [VOICE_COUNT];
    logic [pva_pkg::AGE_W-1:0]     r_next_age;
    logic [CNT_W-1:0]              r_count;

    logic                          r_scan_busy;
    logic [IDX_W-1:0]              r_scan_idx;
    logic                          r_cmp_vld;
    logic [IDX_W-1:0]              r_cmp_idx;
    logic [pva_pkg::AGE_W-1:0]     r_rd_age;
    logic [IDX_W-1:0]              r_best_idx;
    logic [pva_pkg::AGE_W-1:0]     r_best_age;
    logic                          r_scan_done;

    logic [VOICE_COUNT-1:0]        r_pend;

    logic                          r_o_valid;
    logic [pva_pkg::IDX_OUT_W-1:0] r_o_index;
    logic [pva_pkg::NOTE_W-1:0]    r_o_note;
    logic                          r_o_gate;
    logic [pva_pkg::FRAME_W-1:0]   r_o_frame;
    logic [pva_pkg::ACT_OUT_W-1:0] r_o_active;
    logic                          r_o_last;

    logic [VOICE_COUNT-1:0]        w_match_in;
    logic                          w_any_free;
    logic [IDX_W-1:0]              w_free_idx;
    logic [IDX_W-1:0]              w_pick;
    logic [VOICE_COUNT-1:0]        w_low;
    logic [VOICE_COUNT-1:0]        w_rest;
    logic [IDX_W-1:0]              w_low_idx;
    logic                          w_pend_last;
    logic [CNT_W-1:0]              w_cnt_on;
    logic [CNT_W-1:0]              w_cnt_off;

    pva_frame #(
        .BLOCK_FRAMES (BLOCK_FRAMES)
    ) u_frame (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_cmd.load),
        .i_event_time_ns  (i_event_time_ns),
        .i_block_start_ns (i_block_start_ns),
        .o_done           (w_frame_done),
        .o_frame          (w_frame)
    );

    always_comb begin
        w_any_free = ~&r_active;
        w_free_idx = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < VOICE_COUNT; i++) begin
            w_match_in[i] = r_active[i] && (r_note[i] == i_note_number);
        end
    end

    assign w_pick = w_any_free ? w_free_idx : r_best_idx;

    // Releases go out lowest voice first; the final one has nothing left.
    assign w_low       = r_pend & (~r_pend + 1'b1);
    assign w_rest      = r_pend & ~w_low;
    assign w_pend_last = (w_rest == '0);

    always_comb begin
        w_low_idx = '0;
        for (int i = 0; i < VOICE_COUNT; i++) begin
            if (w_low[i]) begin
                w_low_idx = IDX_W'(i);
            end
        end
    end

    assign w_cnt_on  = w_any_free ? (r_count + 1'b1) : r_count;
    assign w_cnt_off = (r_count != '0) ? (r_count - 1'b1) : r_count;

    // Item capture and voice notes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_on      <= i_note_on;
            r_in_note <= i_note_number;
            r_pend    <= i_note_on ? '0 : w_match_in;
        end else if (i_cmd.off_emit) begin
            r_pend <= w_rest;
        end
        if (i_cmd.on_commit) begin
            r_note[w_pick] <= r_in_note;
        end
    end

    // Age memory: one write port for the stamp, one registered read port
    // for the scan. Entries are written before the scan can reach them.
    always_ff @(posedge i_clk) begin
        if (i_cmd.on_commit) begin
            r_age_mem[w_pick] <= r_next_age;
        end
        r_rd_age <= r_age_mem[r_scan_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_next_age <= pva_pkg::AGE_W'(1);
            r_count    <= '0;
        end else if (i_cmd.on_commit) begin
            r_active[w_pick] <= 1'b1;
            r_next_age       <= r_next_age + 1'b1;
            r_count          <= w_cnt_on;
        end else if (i_cmd.off_emit) begin
            r_active[w_low_idx] <= 1'b0;
            r_count             <= w_cnt_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_busy <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_scan_done <= 1'b0;
            r_scan_idx  <= '0;
        end else if (i_cmd.load) begin
            r_scan_busy <= i_note_on;
            r_cmp_vld   <= 1'b0;
            r_scan_done <= !i_note_on;
            r_scan_idx  <= '0;
        end else begin
            r_cmp_vld <= r_scan_busy;
            if (r_scan_busy) begin
                if (r_scan_idx == IDX_W'(VOICE_COUNT - 1)) begin
                    r_scan_busy <= 1'b0;
                end else begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end
            if (r_cmp_vld && (r_cmp_idx == IDX_W'(VOICE_COUNT - 1))) begin
                r_scan_done <= 1'b1;
            end
        end
    end

    // Strict less-than keeps the lowest index on equal ages.
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan_idx;
        if (r_cmp_vld) begin
            if ((r_cmp_idx == '0) || (r_rd_age < r_best_age)) begin
                r_best_idx <= r_cmp_idx;
                r_best_age <= r_rd_age;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.on_commit || i_cmd.off_emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.on_commit) begin
            r_o_index  <= pva_pkg::IDX_OUT_W'(w_pick);
            r_o_note   <= r_in_note;
            r_o_gate   <= 1'b1;
            r_o_frame  <= w_frame;
            r_o_active <= pva_pkg::ACT_OUT_W'(w_cnt_on);
            r_o_last   <= 1'b1;
        end else if (i_cmd.off_emit) begin
            r_o_index  <= pva_pkg::IDX_OUT_W'(w_low_idx);
            r_o_note   <= r_in_note;
            r_o_gate   <= 1'b0;
            r_o_frame  <= w_frame;
            r_o_active <= pva_pkg::ACT_OUT_W'(w_cnt_off);
            r_o_last   <= w_pend_last;
        end
    end

    assign o_status.on         = r_on;
    assign o_status.frame_done = w_frame_done;
    assign o_status.scan_done  = r_scan_done;
    assign o_status.pend_any   = (r_pend != '0);
    assign o_status.pend_last  = w_pend_last;
    assign o_status.out_free   = !r_o_valid || !i_out_stall;

    assign o_out_valid     = r_o_valid;
    assign o_voice_index   = r_o_index;
    assign o_voice_note    = r_o_note;
    assign o_gate          = r_o_gate;
    assign o_frame_offset  = r_o_frame;
    assign o_active_voices = r_o_active;
    assign o_last_result   = r_o_last;

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_active)))
        else $error("active count disagrees with active voices");

    a_emit_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.off_emit |-> (r_pend != '0))
        else $error("release issued with no matching voice left");

    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.on_commit |=> (r_o_valid && r_o_gate))
        else $error("note-on commit did not produce a gate-high result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.on_commit || i_cmd.off_emit) |-> (!r_o_valid || !i_out_stall))
        else $error("result register overwritten while stalled");
`endif

endmodule

@@ src/pva_ctrl.sv @@
// ----------------------------------------------------------------------------
// Voice allocator controller
// Sequences capture, frame and age scan completion, and result issue.
// ----------------------------------------------------------------------------
module pva_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pva_pkg::t_status  i_status,
    output pva_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_WAIT    = 4'b0010,
        S_ON_OUT  = 4'b0100,
        S_OFF_OUT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.on_commit = 1'b0;
        o_cmd.off_emit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_status.frame_done && i_status.scan_done) begin
                    if (i_status.on) begin
                        n_state = S_ON_OUT;
                    end else if (i_status.pend_any) begin
                        n_state = S_OFF_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ON_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.on_commit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_OFF_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.off_emit = 1'b1;
                    if (i_status.pend_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ src/polyphonic_voice_allocator.sv @@
// A note-on result is registered once the age scan, which reads one voice a cycle,
// has covered every voice; a note-off's first release is registered once the frame
// multiply is done. Results wait while the output is stalled. The input is stalled
// until an item is done, so no new item is taken before that. Note-off: one release
// per cycle while the output is not stalled; a note-off with no match is done with the frame.
// Reset (synchronous, active low) marks all voices inactive, sets the age stamp
// to one and the active count to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Polyphonic voice allocator
// Assigns note-on events to the lowest free voice or steals the oldest, and
// releases every voice holding the note of a note-off event.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator #(
    parameter int VOICE_COUNT  = pva_pkg::VOICE_COUNT_DEF,
    parameter int BLOCK_FRAMES = pva_pkg::BLOCK_FRAMES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_note_on,
    input  logic [pva_pkg::NOTE_W-1:0]     i_note_number,
    input  logic [pva_pkg::TIME_W-1:0]     i_event_time_ns,
    input  logic [pva_pkg::TIME_W-1:0]     i_block_start_ns,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pva_pkg::IDX_OUT_W-1:0]  o_voice_index,
    output logic [pva_pkg::NOTE_W-1:0]     o_voice_note,
    output logic                           o_gate,
    output logic [pva_pkg::FRAME_W-1:0]    o_frame_offset,
    output logic [pva_pkg::ACT_OUT_W-1:0]  o_active_voices,
    output logic                           o_last_result
);

    pva_pkg::t_cmd    w_cmd;
    pva_pkg::t_status w_status;

    pva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pva_dpath #(
        .VOICE_COUNT  (VOICE_COUNT),
        .BLOCK_FRAMES (BLOCK_FRAMES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_note_on        (i_note_on),
        .i_note_number    (i_note_number),
        .i_event_time_ns  (i_event_time_ns),
        .i_block_start_ns (i_block_start_ns),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_voice_index    (o_voice_index),
        .o_voice_note     (o_voice_note),
        .o_gate           (o_gate),
        .o_frame_offset   (o_frame_offset),
        .o_active_voices  (o_active_voices),
        .o_last_result    (o_last_result)
    );

endmodule
